// ----- rtl/rgbhsv_pkg.sv -----
// ----------------------------------------------------------------------------
// rgbhsv_pkg
// Shared widths, constants, types and divider step functions for the
// RGB to HSV converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rgbhsv_pkg;

    // component width and derived widths
    localparam int CW     = 8;
    localparam int NW     = CW + 3;       // hue numerator before scaling, < 6*2^CW
    localparam int DVD_W  = CW + 15;      // dividend width of both divides
    localparam int QW     = 16;           // quotient bits produced per divide
    localparam int HW     = 15;           // hue width
    localparam int SW     = 16;           // saturation width
    localparam int SAT_SH = 15;           // Q1.15 scaling

    // 60 degrees in 1/64 degree units
    localparam logic [DVD_W-1:0] HUE_SIXTH = DVD_W'(3840);

    // divider pipeline: bits resolved per stage and number of stages
    localparam int DIV_STEPS = 4;
    localparam int NSTG      = QW / DIV_STEPS;

    // partial remainder plus a shift register that trades dividend bits
    // for quotient bits
    typedef struct packed {
        logic [CW-1:0] rem;
        logic [QW-1:0] lq;
    } t_div_ch;

    // one word in flight through the divider stages
    typedef struct packed {
        t_div_ch       hch;
        t_div_ch       sch;
        logic [CW-1:0] hdiv;
        logic [CW-1:0] sdiv;
        logic          hzero;
        logic          szero;
        logic [CW-1:0] bright;
    } t_dv;

    // one restoring divide step
    function automatic t_div_ch div_step(t_div_ch c, logic [CW-1:0] dv);
        logic [CW:0] sh;
        t_div_ch     o;
        sh   = {c.rem, c.lq[QW-1]};
        o.lq = {c.lq[QW-2:0], 1'b0};
        if (sh >= {1'b0, dv}) begin
            o.rem   = CW'(sh - {1'b0, dv});
            o.lq[0] = 1'b1;
        end else begin
            o.rem = sh[CW-1:0];
        end
        return o;
    endfunction

    // DIV_STEPS steps on both the hue and the saturation divide
    function automatic t_dv div_stage(t_dv w);
        t_dv o;
        o = w;
        for (int j = 0; j < DIV_STEPS; j++) begin
            o.hch = div_step(o.hch, o.hdiv);
            o.sch = div_step(o.sch, o.sdiv);
        end
        return o;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/rgb_to_hsv_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Fully pipelined 8-bit RGB to HSV pixel converter, one pixel per clock.
// ----------------------------------------------------------------------------
// A pixel word is taken on every clock where start is high; busy is always
// low, so the block accepts one word per cycle with no gaps. Each result word
// appears on o_hue/o_saturation/o_brightness for one cycle with o_valid high,
// after passing through one input register, one max/min and
// sector stage, one numerator stage, four divider stages (four quotient bits
// each, restoring division shared in form by the hue and saturation divides)
// and one output register. The divider stage count is set by the 16-bit
// quotient width. Results come out in input order and the receiver cannot
// stall them. Hue is in 1/64 degree (0..23039), saturation is delta/max in
// unsigned Q1.15 (32768 = 1.0), brightness is the max component byte.
// Grey pixels give hue 0; black pixels give saturation 0.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_to_hsv_converter (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic             o_valid,
    output logic [14:0]      o_hue,
    output logic [15:0]      o_saturation,
    output logic [7:0]       o_brightness
);

    localparam int CW       = rgbhsv_pkg::CW;
    localparam int NW       = rgbhsv_pkg::NW;
    localparam int DVD_W    = rgbhsv_pkg::DVD_W;
    localparam int QW       = rgbhsv_pkg::QW;
    localparam int HW       = rgbhsv_pkg::HW;
    localparam int SW       = rgbhsv_pkg::SW;
    localparam int NSTG     = rgbhsv_pkg::NSTG;
    localparam int PIPE_LAT = NSTG + 4;

    // never stalls
    assign busy = 1'b0;

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    logic          r_s0_vld;
    logic [CW-1:0] r_s0_r, r_s0_g, r_s0_b;

    // ------------------------------------------------------------------
    // Stage 1: max, min, delta and hue sector numerator (in units of d/6)
    // ------------------------------------------------------------------
    logic          r_s1_vld;
    logic [NW-1:0] r_s1_n;     // sector*d + signed diff, always >= 0
    logic [CW-1:0] r_s1_d;
    logic [CW-1:0] r_s1_mx;

    logic          red_max, green_max;
    logic [CW-1:0] mx, mn, dl;
    logic [NW:0]   diff;       // signed, one bit wider than n
    logic [NW:0]   d_ext;
    logic [NW:0]   n_num;

    always_comb begin
        // ties go to red, then green
        red_max   = (r_s0_r >= r_s0_g) && (r_s0_r >= r_s0_b);
        green_max = !red_max && (r_s0_g >= r_s0_b);
        if (red_max) begin
            mx = r_s0_r;
        end else if (green_max) begin
            mx = r_s0_g;
        end else begin
            mx = r_s0_b;
        end
        mn = r_s0_r;
        if (r_s0_g < mn) begin
            mn = r_s0_g;
        end
        if (r_s0_b < mn) begin
            mn = r_s0_b;
        end
        dl    = mx - mn;
        d_ext = (NW+1)'(dl);
        if (red_max) begin
            diff  = (NW+1)'(r_s0_g) - (NW+1)'(r_s0_b);
            // floored modulo 6: wrap negative offsets by one full turn
            n_num = diff[NW] ? diff + (d_ext << 2) + (d_ext << 1) : diff;
        end else if (green_max) begin
            diff  = (NW+1)'(r_s0_b) - (NW+1)'(r_s0_r);
            n_num = diff + (d_ext << 1);
        end else begin
            diff  = (NW+1)'(r_s0_r) - (NW+1)'(r_s0_g);
            n_num = diff + (d_ext << 2);
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: scale numerators, load divider stage 0
    //   hue: (n*3840) / d      sat: (d << 15) / max
    // Top QW-free bits start the remainder; both quotients fit in QW bits.
    // ------------------------------------------------------------------
    rgbhsv_pkg::t_dv r_dv [0:NSTG];
    rgbhsv_pkg::t_dv n_dv [1:NSTG];
    logic [NSTG:0]   r_dv_vld;

    logic [DVD_W-1:0] hue_dvd, sat_dvd;
    rgbhsv_pkg::t_dv  n_dv0;

    always_comb begin
        hue_dvd         = DVD_W'(r_s1_n) * rgbhsv_pkg::HUE_SIXTH;
        sat_dvd         = DVD_W'(r_s1_d) << rgbhsv_pkg::SAT_SH;
        n_dv0.hch.rem   = CW'(hue_dvd[DVD_W-1:QW]);
        n_dv0.hch.lq    = hue_dvd[QW-1:0];
        n_dv0.sch.rem   = CW'(sat_dvd[DVD_W-1:QW]);
        n_dv0.sch.lq    = sat_dvd[QW-1:0];
        n_dv0.hdiv      = r_s1_d;
        n_dv0.sdiv      = r_s1_mx;
        n_dv0.hzero     = (r_s1_d == '0);
        n_dv0.szero     = (r_s1_mx == '0);
        n_dv0.bright    = r_s1_mx;
    end

    // ------------------------------------------------------------------
    // Divider stages: DIV_STEPS quotient bits each
    // ------------------------------------------------------------------
    for (genvar k = 0; k < NSTG; k++) begin : g_div
        assign n_dv[k+1] = rgbhsv_pkg::div_stage(r_dv[k]);
    end

    // ------------------------------------------------------------------
    // Output stage
    // ------------------------------------------------------------------
    logic          r_out_vld;
    logic [HW-1:0] r_hue;
    logic [SW-1:0] r_sat;
    logic [CW-1:0] r_bri;

    // control: valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld  <= 1'b0;
            r_s1_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_s0_vld  <= start && !busy;
            r_s1_vld  <= r_s0_vld;
            r_dv_vld  <= {r_dv_vld[NSTG-1:0], r_s1_vld};
            r_out_vld <= r_dv_vld[NSTG];
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_s0_r  <= i_red;
        r_s0_g  <= i_green;
        r_s0_b  <= i_blue;
        r_s1_n  <= n_num[NW-1:0];
        r_s1_d  <= dl;
        r_s1_mx <= mx;
        r_dv[0] <= n_dv0;
        for (int k = 1; k <= NSTG; k++) begin
            r_dv[k] <= n_dv[k];
        end
        r_hue <= r_dv[NSTG].hzero ? '0 : r_dv[NSTG].hch.lq[HW-1:0];
        r_sat <= r_dv[NSTG].szero ? '0 : r_dv[NSTG].sch.lq[SW-1:0];
        r_bri <= r_dv[NSTG].bright;
    end

    assign o_valid      = r_out_vld;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bri;

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##PIPE_LAT o_valid)
        else $error("result word missing at pipeline latency");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_brightness == '0) |-> (o_saturation == '0 && o_hue == '0))
        else $error("black pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_hue < HW'(23040)))
        else $error("hue out of range");

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_saturation <= SW'(32768)))
        else $error("saturation above one");
`endif

endmodule

`default_nettype wire

// ----- tb/rgb_to_hsv_converter_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Self-checking bench for the pipelined RGB to HSV pixel converter. A queue
// of pixel words (corner pixels first, then random pixels shaped toward
// grey pixels, max ties and extreme bytes) feeds a start/busy driver with
// random idle bursts. A monitor predicts hue, saturation and brightness for
// every accepted word and checks each strobed result word in order.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_tb;

    localparam int CW     = rgbhsv_pkg::CW;
    localparam int HW     = rgbhsv_pkg::HW;
    localparam int SW     = rgbhsv_pkg::SW;
    localparam int SAT_SH = rgbhsv_pkg::SAT_SH;

    localparam int CLK_HALF     = 6;     // 12 ns clock
    localparam int RESET_CYCLES = 11;
    localparam int RANDOM_WORDS = 1450;
    localparam int CALM_TAIL    = 150;   // last words go out back to back
    localparam int DRAIN_CYCLES = 24;    // pipeline is 8 deep, leave margin
    localparam int STALL_LIMIT  = 2000;  // cycles with no word moving
    localparam int REPORT_MAX   = 10;

    // 60 degrees in 1/64 degree, and the 360 degree wrap
    localparam int DEG60  = 3840;
    localparam int DEG360 = 6 * DEG60;

    typedef struct {
        logic [CW-1:0] red;
        logic [CW-1:0] green;
        logic [CW-1:0] blue;
    } t_pixel;

    typedef struct {
        logic [HW-1:0] hue;
        logic [SW-1:0] sat;
        logic [CW-1:0] bright;
    } t_hsv;

    logic          i_clk   = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          start   = 1'b0;
    logic [CW-1:0] i_red   = '0;
    logic [CW-1:0] i_green = '0;
    logic [CW-1:0] i_blue  = '0;
    logic          busy;
    logic          o_valid;
    logic [HW-1:0] o_hue;
    logic [SW-1:0] o_saturation;
    logic [CW-1:0] o_brightness;

    t_pixel pixel_q[$];     // words still to be sent, front is on the bus
    t_hsv   hsv_due_q[$];   // predicted result words, oldest first
    t_hsv   hsv_want;
    int     fault_cnt  = 0;
    int     gap_left   = 0;
    int     idle_pct   = 0;
    int     stall_cnt  = 0;

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_valid      (o_valid),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // HSV of one pixel. Max ties go to red, then green. The red sector wraps
    // negative numerators by a full turn before the single truncating divide.
    function automatic t_hsv predict_hsv(input logic [CW-1:0] r, g, b);
        t_hsv res;
        int   ri, gi, bi, mx, mn, d, num;
        ri = r;
        gi = g;
        bi = b;
        mx = ri;
        if (gi > mx) mx = gi;
        if (bi > mx) mx = bi;
        mn = ri;
        if (gi < mn) mn = gi;
        if (bi < mn) mn = bi;
        d = mx - mn;
        res.hue    = '0;
        res.sat    = '0;
        res.bright = CW'(mx);
        if (d != 0) begin
            if (mx == ri) begin
                num = DEG60 * (gi - bi);
                if (num < 0) num += DEG360 * d;
            end else if (mx == gi) begin
                num = DEG60 * (bi - ri) + 2 * DEG60 * d;
            end else begin
                num = DEG60 * (ri - gi) + 4 * DEG60 * d;
            end
            res.hue = HW'(num / d);
        end
        // black pixel keeps saturation at zero
        if (mx != 0) res.sat = SW'((d << SAT_SH) / mx);
        return res;
    endfunction

    task automatic add_pixel(input int r, g, b);
        t_pixel p;
        p.red   = CW'(r);
        p.green = CW'(g);
        p.blue  = CW'(b);
        pixel_q.push_back(p);
    endtask

    // one byte biased toward the ends of the range
    function automatic int edge_byte();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return 1;
            2:       return 254;
            3:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    task automatic build_pixels();
        int kind, v, lo, hi, slot;
        // corner pixels: black, white, grey, primaries, max ties, red wrap
        add_pixel(0, 0, 0);
        add_pixel(255, 255, 255);
        add_pixel(128, 128, 128);
        add_pixel(1, 1, 1);
        add_pixel(255, 0, 0);
        add_pixel(0, 255, 0);
        add_pixel(0, 0, 255);
        add_pixel(255, 0, 1);       // red max, green < blue: wraps
        add_pixel(255, 1, 0);
        add_pixel(255, 255, 0);     // red/green tie, red wins
        add_pixel(0, 255, 255);     // green/blue tie, green wins
        add_pixel(255, 0, 255);     // red/blue tie, red wins
        add_pixel(1, 0, 0);
        add_pixel(0, 0, 1);
        add_pixel(0, 1, 0);
        add_pixel(254, 255, 0);
        add_pixel(0, 1, 255);
        add_pixel(255, 254, 253);
        add_pixel(200, 50, 100);
        add_pixel(1, 2, 3);
        add_pixel(3, 2, 1);
        add_pixel(128, 0, 255);
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            kind = $urandom_range(0, 19);
            if (kind <= 10) begin
                add_pixel($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 255));
            end else if (kind <= 13) begin
                // grey or one step off grey
                v    = $urandom_range(0, 255);
                lo   = (v == 0) ? v : v - $urandom_range(0, 1);
                slot = $urandom_range(0, 2);
                add_pixel(slot == 0 ? lo : v, slot == 1 ? lo : v, slot == 2 ? lo : v);
            end else if (kind <= 16) begin
                // two components share the maximum
                hi   = $urandom_range(0, 255);
                lo   = $urandom_range(0, hi);
                slot = $urandom_range(0, 2);
                add_pixel(slot == 0 ? lo : hi, slot == 1 ? lo : hi, slot == 2 ? lo : hi);
            end else begin
                add_pixel(edge_byte(), edge_byte(), edge_byte());
            end
        end
    endtask

    // Driver: holds a word until start && !busy takes it, then either sends
    // the next one or opens an idle burst. Idle density changes now and then
    // (zero included) and drops to none at the tail.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left <= 0;
        end else begin
            if (start && !busy) void'(pixel_q.pop_front());
            if ($urandom_range(0, 99) == 0) begin
                case ($urandom_range(0, 3))
                    0:       idle_pct <= 0;
                    1:       idle_pct <= 10;
                    2:       idle_pct <= 30;
                    default: idle_pct <= 50;
                endcase
            end
            if (start && busy) begin
                // word not taken yet: hold it
            end else if (gap_left > 0 || pixel_q.size() == 0 ||
                         (pixel_q.size() > CALM_TAIL &&
                          $urandom_range(0, 99) < idle_pct)) begin
                if (gap_left > 0) gap_left <= gap_left - 1;
                else if (pixel_q.size() != 0) gap_left <= $urandom_range(0, 5);
                start   <= 1'b0;
                // junk on the data ports while idle
                i_red   <= CW'($urandom);
                i_green <= CW'($urandom);
                i_blue  <= CW'($urandom);
            end else begin
                start   <= 1'b1;
                i_red   <= pixel_q[0].red;
                i_green <= pixel_q[0].green;
                i_blue  <= pixel_q[0].blue;
            end
        end
    end

    // Monitor: predict on every accepted word, then check the strobed
    // result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) hsv_due_q.push_back(predict_hsv(i_red, i_green, i_blue));
            if (o_valid) begin
                if (hsv_due_q.size() == 0) begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_MAX)
                        $display("%0t: unexpected word hue=%0d sat=%0d bright=%0d",
                                 $realtime, o_hue, o_saturation, o_brightness);
                end else begin
                    hsv_want = hsv_due_q.pop_front();
                    if (o_hue !== hsv_want.hue || o_saturation !== hsv_want.sat ||
                        o_brightness !== hsv_want.bright) begin
                        fault_cnt++;
                        if (fault_cnt <= REPORT_MAX)
                            $display("%0t: mismatch exp h/s/v=%0d/%0d/%0d got %0d/%0d/%0d",
                                     $realtime, hsv_want.hue, hsv_want.sat,
                                     hsv_want.bright, o_hue, o_saturation, o_brightness);
                    end
                end
            end
        end
    end

    // Watchdog: nothing accepted on either side for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            stall_cnt <= 0;
        end else begin
            stall_cnt <= stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin
        build_pixels();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // sample off the active edge so the queues are settled
        @(negedge i_clk);
        while (pixel_q.size() != 0 || start || hsv_due_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fault_cnt == 0 && hsv_due_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
